// ===== design/odp_pkg.sv =====
// Package for the ordered dither pixel block: field widths, payload structs,
// configuration register codes and reset values.
// Has no dependencies; every other design file imports it.
package odp_pkg;

    // Parameter defaults.
    localparam int TABLE_SIDE_MAX_DEF = 8;
    localparam int MAX_WIDTH_DEF      = 4096;

    // Fixed field widths.
    localparam int CHAN_W   = 16;
    localparam int ENTRY_W  = 3;
    localparam int LEVEL_W  = 16;
    localparam int IWIDTH_W = 13;
    localparam int SIDE_W   = 4;
    localparam int SHIFT_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration reset values.
    localparam logic [IWIDTH_W-1:0] IMAGE_WIDTH_RST = 13'd1;
    localparam logic [SIDE_W-1:0]   TABLE_SIDE_RST  = 4'd4;
    localparam logic [SHIFT_W-1:0]  SHIFT_RST       = 4'd0;
    localparam logic [LEVEL_W-1:0]  MAX_LEVEL_RST   = 16'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_TABLE_SIDE   = 2'd1,
        CFG_SHIFT_AMOUNT = 2'd2,
        CFG_MAX_LEVEL    = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_TABLE = 1'b1
    } t_mode;

    typedef struct packed {
        logic                mode;
        logic [CHAN_W-1:0]   red;
        logic [CHAN_W-1:0]   green;
        logic [CHAN_W-1:0]   blue;
        logic                frame_start;
        logic [ENTRY_W-1:0]  entry_row;
        logic [ENTRY_W-1:0]  entry_col;
        logic [CHAN_W-1:0]   entry_value;
    } t_pix_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] out_level;
        logic               is_on;
    } t_pix_out;

endpackage

// ===== design/odp_in_if.sv =====
// Input channel of the ordered dither pixel block: valid, ready and payload.
// Depends on odp_pkg for the payload struct.
interface odp_in_if import odp_pkg::*; ();
    logic    valid;
    logic    ready;
    t_pix_in data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== design/odp_out_if.sv =====
// Output channel of the ordered dither pixel block: valid, ready and payload.
// Depends on odp_pkg for the payload struct.
interface odp_out_if import odp_pkg::*; ();
    logic     valid;
    logic     ready;
    t_pix_out data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== design/ordered_dither_pixel.sv =====
// Top level of the ordered dither pixel block.
// Depends on odp_pkg, odp_in_if and odp_out_if.
//
// Usage:
// Items arrive on i_pix. A mode 0 item is an RGB pixel in raster order and
// yields one result on o_dith; a mode 1 item writes one threshold table entry
// and yields nothing. frame_start on a pixel restarts the row and column
// positions before that pixel is used. Every table entry must be written
// before a pixel reads it. The configuration port writes one register per
// cycle while i_cfg_we is high; the user must use it only while no
// transaction is in flight, and the block itself does not enforce this.
// Order: the grey value and table entry of a pixel are registered at the
// edge that accepts it, and its result is registered in the output stage
// once that stage can advance, and then shows on o_dith. Throughput is one
// item per cycle while o_dith is not stalled; the threshold table is a
// single-port-write, single-read memory and each stage holds one item.
// When the receiver stalls, the output register holds its result, the table
// read stage fills behind it, and then i_pix.ready drops until o_dith moves.
// Reset is synchronous: it empties both stages, restarts the positions and
// loads the register reset values. The table contents are not cleared.
module ordered_dither_pixel import odp_pkg::*; #(
    parameter int TABLE_SIDE_MAX = TABLE_SIDE_MAX_DEF,
    parameter int MAX_WIDTH      = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    odp_in_if.sink                i_pix,
    odp_out_if.source             o_dith
);

    localparam int PW    = $clog2(TABLE_SIDE_MAX);
    localparam int DEPTH = TABLE_SIDE_MAX * TABLE_SIDE_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int WW    = $clog2(MAX_WIDTH + 1);

    // Configuration registers.
    logic [IWIDTH_W-1:0] r_image_width;
    logic [SIDE_W-1:0]   r_table_side;
    logic [SHIFT_W-1:0]  r_shift;
    logic [LEVEL_W-1:0]  r_max_level;

    // Position state.
    logic [CW-1:0] r_col_count, n_col_count;
    logic [PW-1:0] r_col_phase, n_col_phase;
    logic [PW-1:0] r_row_phase, n_row_phase;

    // Threshold memory and pipeline.
    logic [CHAN_W-1:0]  r_table [DEPTH];
    logic [CHAN_W-1:0]  r_thr;
    logic [CHAN_W-1:0]  r_grey;
    logic               r_s1_valid;
    logic               r_out_valid;
    t_pix_out           r_out;

    logic               out_adv;
    logic               in_ready;
    logic               in_acc;
    logic               pix_acc;
    logic               tab_acc;
    logic               tab_in_range;
    logic [AW-1:0]      wr_addr;
    logic [AW-1:0]      rd_addr;
    logic [CW-1:0]      base_cc;
    logic [PW-1:0]      base_cp;
    logic [PW-1:0]      base_rp;
    logic [WW-1:0]      eff_width;
    logic [31:0]        eff_side;
    logic [CHAN_W-1:0]  lo, hi;
    logic [CHAN_W:0]    sum;
    logic [CHAN_W-1:0]  grey;
    logic               on;

    assign out_adv  = !r_out_valid || o_dith.ready;
    assign in_ready = !r_s1_valid || out_adv;
    assign in_acc   = i_pix.valid && in_ready;
    assign pix_acc  = in_acc && (i_pix.data.mode == MODE_PIXEL);
    assign tab_acc  = in_acc && (i_pix.data.mode == MODE_TABLE);

    assign i_pix.ready  = in_ready;
    assign o_dith.valid = r_out_valid;
    assign o_dith.data  = r_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width <= IMAGE_WIDTH_RST;
            r_table_side  <= TABLE_SIDE_RST;
            r_shift       <= SHIFT_RST;
            r_max_level   <= MAX_LEVEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_IMAGE_WIDTH:  r_image_width <= i_cfg_data[IWIDTH_W-1:0];
                CFG_TABLE_SIDE:   r_table_side  <= i_cfg_data[SIDE_W-1:0];
                CFG_SHIFT_AMOUNT: r_shift       <= i_cfg_data[SHIFT_W-1:0];
                CFG_MAX_LEVEL:    r_max_level   <= i_cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamped limits.
    always_comb begin
        if (r_image_width == '0) begin
            eff_width = WW'(1);
        end else if (32'(r_image_width) > 32'(MAX_WIDTH)) begin
            eff_width = WW'(MAX_WIDTH);
        end else begin
            eff_width = WW'(r_image_width);
        end
        if (r_table_side == '0) begin
            eff_side = 32'd1;
        end else if (32'(r_table_side) > 32'(TABLE_SIDE_MAX)) begin
            eff_side = 32'(TABLE_SIDE_MAX);
        end else begin
            eff_side = 32'(r_table_side);
        end
    end

    // Positions for the current pixel and after it.
    always_comb begin
        base_cc = i_pix.data.frame_start ? '0 : r_col_count;
        base_cp = i_pix.data.frame_start ? '0 : r_col_phase;
        base_rp = i_pix.data.frame_start ? '0 : r_row_phase;
        if (32'(base_cc) + 32'd1 >= 32'(eff_width)) begin
            n_col_count = '0;
            n_col_phase = '0;
            n_row_phase = (32'(base_rp) + 32'd1 >= eff_side) ? '0 : PW'(base_rp + 1'b1);
        end else begin
            n_col_count = CW'(base_cc + 1'b1);
            n_col_phase = (32'(base_cp) + 32'd1 >= eff_side) ? '0 : PW'(base_cp + 1'b1);
            n_row_phase = base_rp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_col_phase <= '0;
            r_row_phase <= '0;
        end else if (pix_acc) begin
            r_col_count <= n_col_count;
            r_col_phase <= n_col_phase;
            r_row_phase <= n_row_phase;
        end
    end

    // Table addressing: row-major with a row pitch of the largest side.
    assign tab_in_range = (32'(i_pix.data.entry_row) < 32'(TABLE_SIDE_MAX)) &&
                          (32'(i_pix.data.entry_col) < 32'(TABLE_SIDE_MAX));
    assign wr_addr = AW'(32'(i_pix.data.entry_row) * 32'(TABLE_SIDE_MAX) +
                         32'(i_pix.data.entry_col));
    assign rd_addr = AW'(32'(base_rp) * 32'(TABLE_SIDE_MAX) + 32'(base_cp));

    always_ff @(posedge i_clk) begin
        if (tab_acc && tab_in_range) begin
            r_table[wr_addr] <= i_pix.data.entry_value;
        end
        if (pix_acc) begin
            r_thr <= r_table[rd_addr];
        end
    end

    // Grey value: midpoint of the smallest and largest channel, shifted right by r_shift.
    always_comb begin
        lo = i_pix.data.red;
        hi = i_pix.data.red;
        if (i_pix.data.green < lo) lo = i_pix.data.green;
        if (i_pix.data.green > hi) hi = i_pix.data.green;
        if (i_pix.data.blue < lo)  lo = i_pix.data.blue;
        if (i_pix.data.blue > hi)  hi = i_pix.data.blue;
        sum  = {1'b0, lo} + {1'b0, hi};
        grey = sum[CHAN_W:1] >> r_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_ready) begin
            r_s1_valid <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_grey <= grey;
        end
    end

    // Output stage.
    assign on = (r_grey >= r_thr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_adv && r_s1_valid) begin
            r_out.out_level <= on ? r_max_level : '0;
            r_out.is_on     <= on;
        end
    end

endmodule

// ===== design/odp_checker.sv =====
// Port-level checker for the ordered dither pixel block, with its bind.
// Depends on odp_pkg and on the ordered_dither_pixel top level.
module odp_checker import odp_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_ready,
    input logic     i_out_valid,
    input logic     i_out_ready,
    input t_pix_out i_out_data
);

    // A stalled result stays in place.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    // A pixel that is off always shows level zero.
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.is_on |-> i_out_data.out_level == '0)
        else $error("off pixel with nonzero level");

    // With the output register empty, the input side is never blocked.
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input blocked while output empty");

    // Reset empties the output.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind ordered_dither_pixel odp_checker u_odp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_dith.valid),
    .i_out_ready (o_dith.ready),
    .i_out_data  (o_dith.data)
);
